// ----- src/fbfla_pkg.sv -----
// Package for the fixed-size block free-list allocator.
// Holds field widths, mode, status and register codes, and parameter defaults.
// It has no dependencies. Every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package fbfla_pkg;

  // Field widths taken from the interface definition.
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PORT_AW   = 32;
  localparam int unsigned BASE_W    = 32;
  localparam int unsigned BSIZE_W   = 16;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned SPAN_W    = BSIZE_W + IDX_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 32;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_BLOCKS = 255;
  localparam int unsigned DEF_ADDR_WIDTH = 32;

  // Operation codes on the mode field.
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_OWNED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

endpackage

`default_nettype wire

// ----- src/fixed_block_free_list_allocator_unit.sv -----
// Fixed-size block free-list allocator, top level; one item in flight, none overlap.
// Deallocating an owned block runs the bit-serial offset divider to find its index;
// initialize writes one link for each block of the region.
// A new item can be accepted at the edge that takes the result; the receiver cannot stall.
// Reset clears the configuration registers, head, free count and region flag, but not the link store.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator_unit
  import fbfla_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Item channel.
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [MODE_W-1:0]    mode_i,
  input  wire logic [PORT_AW-1:0]   address_i,
  // Result beat.
  output logic                      done_o,
  output logic      [STATUS_W-1:0]  status_o,
  output logic      [PORT_AW-1:0]   block_address_o,
  output logic                      owns_o,
  output logic                      has_free_o,
  output logic                      all_free_o,
  output logic      [IDX_W-1:0]     free_count_o,
  // Configuration write channel.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DW-1:0]    cfg_data_i
);

  localparam int unsigned AW  = ADDR_WIDTH;
  localparam int unsigned MIW = $clog2(MAX_BLOCKS);
  // Width in which an offset and the region span are compared.
  localparam int unsigned CW  = (AW > SPAN_W) ? AW : SPAN_W;
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_LINK,
    S_DIV,
    S_INIT
  } state_e;

  // Configuration registers.
  logic [BASE_W-1:0]  base_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic [IDX_W-1:0]   count_q;

  // Allocator state and registered result beat.
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   free_q, free_d;
  logic               region_q, region_d;
  logic               done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [PORT_AW-1:0] baddr_q, baddr_d;
  logic               owns_q, owns_d;
  logic               has_free_q, has_free_d;
  logic               all_free_q, all_free_d;
  logic [IDX_W-1:0]   free_cnt_q, free_cnt_d;

  // Per-item working registers.
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [SPAN_W-1:0]  span_q, span_d;
  logic [SPAN_W-1:0]  prod_q, prod_d;
  logic [AW-1:0]      offset_q, offset_d;
  logic               ge_q, ge_d;
  logic [IDX_W-1:0]   init_cnt_q, init_cnt_d;

  // Link store and divider hookup.
  logic               mem_we, mem_re;
  logic [MIW-1:0]     mem_waddr;
  logic [IDX_W-1:0]   mem_wdata, mem_rdata;
  logic               div_start, div_done;
  logic [IDX_W-1:0]   div_quo;

  logic [IDX_W-1:0]   eff_count;
  logic [AW-1:0]      base_m;
  logic               accept;
  logic               owns_c;
  logic               emit;
  logic               link_ok_q;

  // A block count above the store depth is clipped to the depth.
  assign eff_count = (count_q > MAX_IDX) ? MAX_IDX : count_q;
  assign base_m    = AW'(base_q);
  assign accept    = start && (state_q == S_IDLE);
  assign busy      = (state_q != S_IDLE);

  // An address is owned when the region has been set up with a nonzero size
  // and count, and base <= address < base + size * count.
  assign owns_c = region_q && (bsize_q != '0) && (eff_count != '0) && ge_q &&
                  (CW'(offset_q) < CW'(span_q));

  // Configuration: always ready; writes beyond the register list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bsize_q <= '0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASE_ADDRESS: base_q  <= cfg_data_i[BASE_W-1:0];
        REG_BLOCK_SIZE:   bsize_q <= cfg_data_i[BSIZE_W-1:0];
        REG_BLOCK_COUNT:  count_q <= cfg_data_i[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Main sequencer. Every item ends in exactly one cycle with emit set, which
  // loads the result beat; the beat shows on the outputs in the next cycle.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    free_d     = free_q;
    region_d   = region_q;
    done_d     = 1'b0;
    status_d   = status_q;
    baddr_d    = baddr_q;
    owns_d     = owns_q;
    has_free_d = has_free_q;
    all_free_d = all_free_q;
    free_cnt_d = free_cnt_q;

    mode_d     = mode_q;
    addr_d     = addr_q;
    span_d     = span_q;
    prod_d     = prod_q;
    offset_d   = offset_q;
    ge_d       = ge_q;
    init_cnt_d = init_cnt_q;

    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = mode_i;
          addr_d = AW'(address_i);
          if (mode_i == MODE_INIT) begin
            // Initialize always drops the old list first.
            head_d     = '0;
            free_d     = '0;
            region_d   = 1'b0;
            init_cnt_d = '0;
            if ((bsize_q == '0) || (eff_count == '0)) begin
              emit     = 1'b1;
              status_d = STATUS_NOT_OWNED;
              owns_d   = 1'b0;
              baddr_d  = '0;
            end else begin
              state_d = S_INIT;
            end
          end else begin
            state_d = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        // Two narrow products and the offset, registered for the next step.
        span_d   = SPAN_W'(bsize_q) * SPAN_W'(eff_count);
        prod_d   = SPAN_W'(bsize_q) * SPAN_W'(head_q);
        offset_d = addr_q - base_m;
        ge_d     = (addr_q >= base_m);
        if (mode_q == MODE_ALLOC) begin
          owns_d  = 1'b0;
          baddr_d = '0;
          if (!region_q) begin
            emit     = 1'b1;
            status_d = STATUS_NOT_OWNED;
            state_d  = S_IDLE;
          end else if (free_q == '0) begin
            emit     = 1'b1;
            status_d = STATUS_NO_FREE;
            state_d  = S_IDLE;
          end else begin
            // Fetch the link of the head; a head beyond the store links to zero.
            mem_re  = (head_q < MAX_IDX);
            state_d = S_LINK;
          end
        end else begin
          state_d = S_CHECK;
        end
      end

      S_LINK: begin
        emit     = 1'b1;
        status_d = STATUS_OK;
        baddr_d  = PORT_AW'(base_m + AW'(prod_q));
        head_d   = link_ok_q ? mem_rdata : '0;
        free_d   = free_q - 1'b1;
        state_d  = S_IDLE;
      end

      S_CHECK: begin
        baddr_d = '0;
        owns_d  = owns_c;
        if (!owns_c) begin
          emit     = 1'b1;
          status_d = STATUS_NOT_OWNED;
          state_d  = S_IDLE;
        end else if (mode_q == MODE_DEALLOC) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          emit     = 1'b1;
          status_d = STATUS_OK;
          state_d  = S_IDLE;
        end
      end

      S_DIV: begin
        if (div_done) begin
          // Push the freed index in front of the current head. A double free is
          // not caught; the free count stops at its maximum.
          mem_we    = (div_quo < MAX_IDX);
          mem_waddr = div_quo[MIW-1:0];
          mem_wdata = head_q;
          head_d    = div_quo;
          free_d    = (free_q == '1) ? free_q : free_q + 1'b1;
          emit      = 1'b1;
          status_d  = STATUS_OK;
          state_d   = S_IDLE;
        end
      end

      S_INIT: begin
        // Link entry i to i + 1, one entry per cycle.
        mem_we     = 1'b1;
        mem_waddr  = init_cnt_q[MIW-1:0];
        mem_wdata  = init_cnt_q + 1'b1;
        init_cnt_d = init_cnt_q + 1'b1;
        if (init_cnt_q == eff_count - 1'b1) begin
          free_d   = eff_count;
          region_d = 1'b1;
          emit     = 1'b1;
          status_d = STATUS_OK;
          owns_d   = 1'b0;
          baddr_d  = '0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Summary fields of the beat follow the free count after this item.
    if (emit) begin
      done_d     = 1'b1;
      has_free_d = (free_d != '0);
      all_free_d = (free_d == eff_count);
      free_cnt_d = free_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      free_q     <= '0;
      region_q   <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= STATUS_OK;
      baddr_q    <= '0;
      owns_q     <= 1'b0;
      has_free_q <= 1'b0;
      all_free_q <= 1'b0;
      free_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      free_q     <= free_d;
      region_q   <= region_d;
      done_q     <= done_d;
      status_q   <= status_d;
      baddr_q    <= baddr_d;
      owns_q     <= owns_d;
      has_free_q <= has_free_d;
      all_free_q <= all_free_d;
      free_cnt_q <= free_cnt_d;
    end
  end

  // Working registers carry no reset; each is written before it is read.
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    addr_q     <= addr_d;
    span_q     <= span_d;
    prod_q     <= prod_d;
    offset_q   <= offset_d;
    ge_q       <= ge_d;
    init_cnt_q <= init_cnt_d;
    link_ok_q  <= mem_re;
  end

  fbfla_mem #(
    .DEPTH (MAX_BLOCKS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q[MIW-1:0]),
    .rdata_o (mem_rdata)
  );

  fbfla_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (SPAN_W'(offset_q)),
    .divisor_i  (bsize_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign block_address_o = baddr_q;
  assign owns_o          = owns_q;
  assign has_free_o      = has_free_q;
  assign all_free_o      = all_free_q;
  assign free_count_o    = free_cnt_q;

endmodule

`default_nettype wire

// ----- src/fbfla_mem.sv -----
// Link store of the allocator: one write port, one read port, registered read.
// Depends on fbfla_pkg for the link width.
`timescale 1ns / 1ps
`default_nettype none

module fbfla_mem
  import fbfla_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_BLOCKS
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [IDX_W-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [IDX_W-1:0]         rdata_o
);

  logic [IDX_W-1:0] mem_q [DEPTH];
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/fbfla_div.sv -----
// Restoring divider that turns a region offset into a block index, one bit a cycle.
// Depends on fbfla_pkg for the offset, block size and index widths.
`timescale 1ns / 1ps
`default_nettype none

module fbfla_div
  import fbfla_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SPAN_W-1:0]  dividend_i,
  input  wire logic [BSIZE_W-1:0] divisor_i,
  output logic                    done_o,
  output logic      [IDX_W-1:0]   quotient_o
);

  localparam int unsigned STEP_W = $clog2(IDX_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [SPAN_W-1:0] rem_q, dsh_q;
  logic [IDX_W-1:0]  quo_q;
  logic              fits;

  // The quotient is known to stay below 2^IDX_W, so the divisor starts
  // shifted up by IDX_W-1 places.
  assign fits = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(IDX_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= SPAN_W'(divisor_i) << (IDX_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[IDX_W-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
